@@ rtl/ps2_mouse_packet_assembler_macros.svh @@
// ----------------------------------------------------------------------------
// PS/2 mouse packet assembler assertion macros
// Concurrent check wrappers; empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_ASSEMBLER_MACROS_SVH
`define PS2_MOUSE_PACKET_ASSEMBLER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define PS2MPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define PS2MPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PS2MPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PS2MPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/ps2mpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpa_pkg
// Shared types, field widths and codes of the PS/2 mouse packet assembler.
// ----------------------------------------------------------------------------
package ps2mpa_pkg;

    // Accumulator width default
    localparam int ACCUM_BITS_DEF = 32;
    localparam int TOTAL_BITS     = 32;

    // Request action codes
    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_POLL = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_PACKET = 2'd1;
    localparam logic [1:0] KIND_POLL   = 2'd2;

    // Controller status bits
    localparam int STAT_READY_BIT = 0;
    localparam int STAT_AUX_BIT   = 5;

    // Packet flag byte bits
    localparam int FLAG_SYNC_BIT  = 3;
    localparam int FLAG_XSIGN_BIT = 4;
    localparam int FLAG_YSIGN_BIT = 5;
    localparam int FLAG_XOVF_BIT  = 6;
    localparam int FLAG_YOVF_BIT  = 7;
    localparam int BUTTON_BITS    = 3;

    // Phase at which a packet completes
    localparam logic [1:0] PHASE_LAST_STD   = 2'd2;
    localparam logic [1:0] PHASE_LAST_WHEEL = 2'd3;

    typedef struct packed {
        logic       action;
        logic [7:0] ctrl_status;
        logic [7:0] data_byte;
    } ps2mpa_item_t;

    typedef struct packed {
        logic [1:0]                   result_kind;
        logic signed [8:0]            move_dx;
        logic signed [9:0]            move_dy;
        logic signed [7:0]            wheel_delta;
        logic signed [9:0]            scroll_rows;
        logic [BUTTON_BITS-1:0]       buttons;
        logic signed [TOTAL_BITS-1:0] total_dx;
        logic signed [TOTAL_BITS-1:0] total_dy;
        logic                         had_data;
    } ps2mpa_result_t;

endpackage

@@ rtl/ps2mpa_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpa_in_reg
// Input register: takes one slave request per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module ps2mpa_in_reg
    import ps2mpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  ps2mpa_item_t item_in,
    input  logic         advance,
    output logic         item_valid,
    output ps2mpa_item_t item_out
);

    logic         valid_reg;
    logic         valid_next;
    ps2mpa_item_t item_reg;

    // Fill on load, empty when the held request moves on
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

@@ rtl/ps2mpa_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpa_core
// Packet framing, sign extension, accumulators and result formation.
// ----------------------------------------------------------------------------
module ps2mpa_core
    import ps2mpa_pkg::*;
#(
    parameter int ACCUM_BITS = ACCUM_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_bit,
    input  logic           fire,
    input  ps2mpa_item_t   item,
    output ps2mpa_result_t result
);

    localparam int WIDE_BITS = (ACCUM_BITS > TOTAL_BITS) ? ACCUM_BITS : TOTAL_BITS;

    logic                   wheel_mode_reg;
    logic [1:0]             phase_reg;
    logic [1:0]             phase_next;
    logic [7:0]             pkt_reg [3];
    logic [ACCUM_BITS-1:0]  sum_dx_reg;
    logic [ACCUM_BITS-1:0]  sum_dx_next;
    logic [ACCUM_BITS-1:0]  sum_dy_reg;
    logic [ACCUM_BITS-1:0]  sum_dy_next;
    logic [BUTTON_BITS-1:0] button_reg;
    logic [BUTTON_BITS-1:0] button_next;
    logic                   pending_reg;
    logic                   pending_next;

    logic                   is_poll;
    logic                   byte_ok;
    logic                   sync_bad;
    logic                   take_byte;
    logic                   completes;
    logic                   store_byte;
    logic                   overflow;
    logic                   accept_pkt;
    logic [7:0]             flags;
    logic [7:0]             dy_byte;
    logic [8:0]             dx9;
    logic [8:0]             dy9;
    logic [9:0]             neg_dy10;
    logic [7:0]             wheel8;
    logic [9:0]             wheel10;
    logic [ACCUM_BITS-1:0]  dx_ext;
    logic [ACCUM_BITS-1:0]  dy_ext;
    logic [WIDE_BITS-1:0]   wide_dx;
    logic [WIDE_BITS-1:0]   wide_dy;

    // Classify the request
    assign is_poll   = (item.action == ACTION_POLL);
    assign byte_ok   = item.ctrl_status[STAT_READY_BIT] & item.ctrl_status[STAT_AUX_BIT];
    assign sync_bad  = (phase_reg == 2'd0) && !item.data_byte[FLAG_SYNC_BIT];
    assign take_byte = !is_poll && byte_ok && !sync_bad;
    assign completes = wheel_mode_reg ? (phase_reg >= PHASE_LAST_WHEEL)
                                      : (phase_reg >= PHASE_LAST_STD);
    assign store_byte = fire && take_byte && (phase_reg != 2'd3);

    // Assemble packet fields; the dy byte bypasses the store when it ends the packet
    assign flags    = pkt_reg[0];
    assign dy_byte  = (phase_reg == 2'd2) ? item.data_byte : pkt_reg[2];
    assign dx9      = {flags[FLAG_XSIGN_BIT], pkt_reg[1]};
    assign dy9      = {flags[FLAG_YSIGN_BIT], dy_byte};
    assign overflow = flags[FLAG_XOVF_BIT] | flags[FLAG_YOVF_BIT];
    assign accept_pkt = take_byte && completes && !overflow;

    assign neg_dy10 = 10'd0 - {dy9[8], dy9};
    assign wheel8   = wheel_mode_reg ? item.data_byte : 8'd0;
    assign wheel10  = {{2{wheel8[7]}}, wheel8};

    assign dx_ext  = ACCUM_BITS'($signed(dx9));
    assign dy_ext  = ACCUM_BITS'($signed(dy9));
    assign wide_dx = WIDE_BITS'($signed(sum_dx_reg));
    assign wide_dy = WIDE_BITS'($signed(sum_dy_reg));

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        sum_dx_next  = sum_dx_reg;
        sum_dy_next  = sum_dy_reg;
        button_next  = button_reg;
        pending_next = pending_reg;
        if (is_poll)
        begin
            sum_dx_next  = '0;
            sum_dy_next  = '0;
            pending_next = 1'b0;
        end
        else if (take_byte)
        begin
            if (completes)
            begin
                phase_next = 2'd0;
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
            end
            if (accept_pkt)
            begin
                sum_dx_next  = sum_dx_reg + dx_ext;
                sum_dy_next  = sum_dy_reg - dy_ext;
                button_next  = flags[BUTTON_BITS-1:0];
                pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mode_reg <= 1'b0;
            phase_reg      <= 2'd0;
            sum_dx_reg     <= '0;
            sum_dy_reg     <= '0;
            button_reg     <= '0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wheel_mode_reg <= cfg_bit;
            end
            if (fire)
            begin
                phase_reg   <= phase_next;
                sum_dx_reg  <= sum_dx_next;
                sum_dy_reg  <= sum_dy_next;
                button_reg  <= button_next;
                pending_reg <= pending_next;
            end
        end
    end

    // Packet byte store
    always_ff @(posedge clk)
    begin
        if (store_byte)
        begin
            pkt_reg[phase_reg] <= item.data_byte;
        end
    end

    // Form the result
    always_comb
    begin
        result             = '0;
        result.result_kind = KIND_NONE;
        result.buttons     = button_next;
        if (is_poll)
        begin
            result.result_kind = KIND_POLL;
            result.total_dx    = wide_dx[TOTAL_BITS-1:0];
            result.total_dy    = wide_dy[TOTAL_BITS-1:0];
            result.had_data    = pending_reg;
        end
        else if (accept_pkt)
        begin
            result.result_kind = KIND_PACKET;
            result.move_dx     = dx9;
            result.move_dy     = neg_dy10;
            result.wheel_delta = wheel8;
            result.scroll_rows = {wheel10[8:0], 1'b0} + wheel10;
        end
    end

endmodule

@@ rtl/ps2mpa_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpa_out_reg
// Result register feeding the master channel.
// ----------------------------------------------------------------------------
module ps2mpa_out_reg
    import ps2mpa_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           result_valid,
    input  ps2mpa_result_t result_in,
    output logic           out_valid,
    output ps2mpa_result_t result_out
);

    logic           valid_reg;
    ps2mpa_result_t result_reg;

    // Refill whenever the register is free or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= result_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result_valid)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

@@ rtl/ps2_mouse_packet_assembler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_assembler
// Rebuilds PS/2 mouse packets from controller bytes and keeps movement totals.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one request per transfer, either a controller byte
//   with its status or a poll. Every request yields exactly one result on the
//   master channel (m_*): nothing accepted, packet accepted, or poll reply.
//   Config channel (cfg_*): wheel_mode, always ready; write it only while no
//   request is in flight.
// Path: a taken request is held in the input register, and its result is
//   captured in the result register when the pipeline advances.
// Throughput: one request per cycle unless stalled; framing, sign extension
//   and accumulator add/subtract fit in the single stage between registers.
// Reset: clears packet phase, totals, buttons, pending flag, wheel_mode and
//   both pipeline valid flags.
// Stall: while m_tready is low the held result stays, one more request is
//   captured in the input register, then s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_assembler_macros.svh"

module ps2_mouse_packet_assembler
    import ps2mpa_pkg::*;
#(
    parameter int ACCUM_BITS = ACCUM_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [7:0] ctrl_status, [15:8] data_byte
    input  logic [0:0]   s_tuser,   // [0] action
    // Result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // [8:0] move_dx, [18:9] move_dy,
                                    // [26:19] wheel_delta, [36:27] scroll_rows,
                                    // [39:37] buttons, [71:40] total_dx,
                                    // [103:72] total_dy, [104] had_data,
                                    // [111:105] zero
    output logic [1:0]   m_tuser,   // [1:0] result_kind
    // Configuration channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_data   // [0] wheel_mode
);

    ps2mpa_item_t   item_in;
    ps2mpa_item_t   item_q;
    ps2mpa_result_t result_d;
    ps2mpa_result_t result_q;
    logic           item_valid;
    logic           advance;
    logic           load;
    logic           fire;

    // Pipeline control
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = !item_valid || advance;
    assign load     = s_tvalid && s_tready;
    assign fire     = item_valid && advance;
    assign cfg_ready = 1'b1;

    assign item_in.action      = s_tuser[0];
    assign item_in.ctrl_status = s_tdata[7:0];
    assign item_in.data_byte   = s_tdata[15:8];

    ps2mpa_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item_q)
    );

    ps2mpa_core #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_bit (cfg_data[0]),
        .fire    (fire),
        .item    (item_q),
        .result  (result_d)
    );

    ps2mpa_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .result_valid (item_valid),
        .result_in    (result_d),
        .out_valid    (m_tvalid),
        .result_out   (result_q)
    );

    // Pack result fields
    assign m_tuser = result_q.result_kind;
    assign m_tdata = {7'd0,
                      result_q.had_data,
                      result_q.total_dy,
                      result_q.total_dx,
                      result_q.buttons,
                      result_q.scroll_rows,
                      result_q.wheel_delta,
                      result_q.move_dy,
                      result_q.move_dx};

    // Input side stalls only behind a stalled result
    `PS2MPA_ASSERT_SAME(a_stall_cause, clk, rst_n, !s_tready,
        m_tvalid && !m_tready, "request channel stalled without a stalled result")
    // Packet result carries no totals
    `PS2MPA_ASSERT_SAME(a_pkt_no_totals, clk, rst_n, m_tvalid && (m_tuser == KIND_PACKET),
        (m_tdata[104:40] == 65'd0), "packet result carries poll fields")
    // Poll and empty results carry no move
    `PS2MPA_ASSERT_SAME(a_no_move, clk, rst_n, m_tvalid && (m_tuser != KIND_PACKET),
        (m_tdata[36:0] == 37'd0), "non-packet result carries move fields")
    // Hold a stalled result unchanged until it is taken
    `PS2MPA_ASSERT_NEXT(a_held_stall, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed before transfer")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PS/2 mouse packet assembler. A driver offers
// controller bytes and polls from a backlog in random bursts; a monitor takes
// results under a random stall pattern and checks each one, field by field,
// against an in-bench model of packet framing, overflow drop and movement
// totals. Both packet sizes are exercised, including switching size mid-packet.
// ----------------------------------------------------------------------------
module tb;
    import ps2mpa_pkg::*;

    localparam int ROWS_PER_TICK = 3;
    localparam int HOLD_CYCLES   = 80;

    typedef struct {
        ps2mpa_item_t req;
        bit           wait_idle;
    } queued_req_t;

    typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_RARE, RX_TIGHT} rx_style_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata   = '0;
    logic [0:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [0:0]   cfg_data  = '0;

    // Bench copy of the block state
    logic                         wheel_on = 1'b0;
    logic [1:0]                   frame_pos = '0;
    logic [7:0]                   frame_buf [3] = '{default: '0};
    logic signed [TOTAL_BITS-1:0] x_total = '0;
    logic signed [TOTAL_BITS-1:0] y_total = '0;
    logic [BUTTON_BITS-1:0]       btn_state = '0;
    logic                         moved_since_poll = 1'b0;

    queued_req_t    requests_todo [$];
    ps2mpa_result_t reports_due [$];
    int unsigned    mismatches = 0;
    int unsigned    burst_left = 0;
    int unsigned    gap_left = 0;
    int unsigned    hold_requests = 0;
    int unsigned    holds_done = 0;
    int unsigned    hold_left = 0;
    int unsigned    rx_cycles = 0;
    rx_style_t      rx_style = RX_OPEN;

    ps2_mouse_packet_assembler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Advance the model by one request and return the result it must produce
    function automatic ps2mpa_result_t packet_report(ps2mpa_item_t rq);
        ps2mpa_result_t    rep;
        logic [1:0]        last_pos;
        logic [7:0]        flags;
        logic signed [9:0] dx;
        logic signed [9:0] dy;
        logic signed [7:0] tilt;
        rep = '0;
        rep.buttons = btn_state;
        if (rq.action == ACTION_POLL)
        begin
            rep.result_kind = KIND_POLL;
            rep.total_dx    = x_total;
            rep.total_dy    = y_total;
            rep.had_data    = moved_since_poll;
            x_total          = '0;
            y_total          = '0;
            moved_since_poll = 1'b0;
            return rep;
        end
        // Drop bytes that are not ready or not from the aux port
        if (!rq.ctrl_status[STAT_READY_BIT] || !rq.ctrl_status[STAT_AUX_BIT])
            return rep;
        // Drop an unsynced first byte
        if (frame_pos == 2'd0 && !rq.data_byte[FLAG_SYNC_BIT])
            return rep;
        last_pos = wheel_on ? PHASE_LAST_WHEEL : PHASE_LAST_STD;
        if (frame_pos < last_pos)
        begin
            frame_buf[frame_pos] = rq.data_byte;
            frame_pos = frame_pos + 2'd1;
            return rep;
        end
        // Final byte; a fourth byte in 3-byte mode closes the packet unused
        if (frame_pos != 2'd3)
            frame_buf[frame_pos] = rq.data_byte;
        frame_pos = 2'd0;
        flags = frame_buf[0];
        dx = {{2{flags[FLAG_XSIGN_BIT]}}, frame_buf[1]};
        dy = {{2{flags[FLAG_YSIGN_BIT]}}, frame_buf[2]};
        if (flags[FLAG_XOVF_BIT] || flags[FLAG_YOVF_BIT])
            return rep;
        x_total = x_total + TOTAL_BITS'(dx);
        y_total = y_total - TOTAL_BITS'(dy);
        btn_state = flags[BUTTON_BITS-1:0];
        moved_since_poll = 1'b1;
        tilt = wheel_on ? rq.data_byte : 8'sd0;
        rep.result_kind = KIND_PACKET;
        rep.move_dx     = dx[8:0];
        rep.move_dy     = -dy;
        rep.wheel_delta = tilt;
        rep.scroll_rows = 10'(tilt * ROWS_PER_TICK);
        rep.buttons     = btn_state;
        return rep;
    endfunction

    function automatic void add_req(logic act, logic [7:0] status, logic [7:0] data,
                                    bit wait_idle = 1'b0);
        queued_req_t q;
        q.req.action      = act;
        q.req.ctrl_status = status;
        q.req.data_byte   = data;
        q.wait_idle       = wait_idle;
        requests_todo.push_back(q);
    endfunction

    function automatic void add_ignored_byte();
        logic [7:0] st;
        st = 8'($urandom);
        if ($urandom_range(0, 1) == 0)
            st[STAT_READY_BIT] = 1'b0;
        else
            st[STAT_AUX_BIT] = 1'b0;
        add_req(ACTION_BYTE, st, 8'($urandom));
    endfunction

    // Queue one packet byte, now and then preceded by a byte the block ignores
    function automatic void add_packet_byte(logic [7:0] b);
        logic [7:0] st;
        if ($urandom_range(0, 15) == 0)
            add_ignored_byte();
        st = 8'($urandom);
        st[STAT_READY_BIT] = 1'b1;
        st[STAT_AUX_BIT]   = 1'b1;
        add_req(ACTION_BYTE, st, b);
    endfunction

    function automatic logic [7:0] pick_move();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'h7F;
            2:       b = 8'h80;
            3:       b = 8'hFF;
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    function automatic void queue_packet(bit four_bytes);
        logic [7:0] flags;
        flags = 8'($urandom);
        flags[FLAG_SYNC_BIT] = 1'b1;
        if ($urandom_range(0, 9) != 0)
        begin
            flags[FLAG_XOVF_BIT] = 1'b0;
            flags[FLAG_YOVF_BIT] = 1'b0;
        end
        add_packet_byte(flags);
        add_packet_byte(pick_move());
        add_packet_byte(pick_move());
        if (four_bytes)
            add_packet_byte(pick_move());
    endfunction

    // Mostly well-formed packets, with some wrong-size packets, noise and polls
    function automatic void queue_random(int unsigned count);
        int unsigned made;
        int unsigned pick;
        logic [7:0]  st;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                queue_packet(wheel_on);
                made += wheel_on ? 4 : 3;
            end
            else if (pick < 80)
            begin
                queue_packet(!wheel_on);
                made += wheel_on ? 3 : 4;
            end
            else if (pick < 88)
            begin
                st = 8'($urandom);
                add_req(ACTION_BYTE, st, 8'($urandom));
                if (st[STAT_READY_BIT] && st[STAT_AUX_BIT])
                    made++;
            end
            else if (pick < 95)
                add_ignored_byte();
            else
            begin
                add_req(ACTION_POLL, 8'($urandom), 8'($urandom));
                made++;
            end
        end
    endfunction

    task automatic wait_idle();
        while (requests_todo.size() != 0 || reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_wheel_mode(logic mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        wheel_on = mode;
        cfg_valid <= 1'b0;
    endtask

    task check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Offer the oldest queued request; record each accepted one in the model
    always @(posedge clk)
    begin : drive_proc
        ps2mpa_item_t taken;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                taken = {s_tuser[0], s_tdata[7:0], s_tdata[15:8]};
                reports_due.push_back(packet_report(taken));
                void'(requests_todo.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (requests_todo.size() == 0 ||
                         (requests_todo[0].wait_idle && reports_due.size() != 0))
                    s_tvalid <= 1'b0;
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= requests_todo[0].req.action;
                    s_tdata  <= {requests_todo[0].req.data_byte,
                                 requests_todo[0].req.ctrl_status};
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    // Stall the result side on a changing pattern, with long hold-offs on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycles++;
            if (rx_cycles % 128 == 0)
                rx_style = rx_style_t'($urandom_range(0, 3));
            if (holds_done != hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_style)
                    RX_OPEN:  m_tready <= 1'b1;
                    RX_HALF:  m_tready <= ($urandom_range(0, 1) == 0);
                    RX_RARE:  m_tready <= ($urandom_range(0, 7) != 0);
                    default:  m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Check each taken result against the oldest expectation
    always @(posedge clk)
    begin : check_proc
        ps2mpa_result_t got;
        ps2mpa_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.result_kind = m_tuser;
            got.move_dx     = m_tdata[8:0];
            got.move_dy     = m_tdata[18:9];
            got.wheel_delta = m_tdata[26:19];
            got.scroll_rows = m_tdata[36:27];
            got.buttons     = m_tdata[39:37];
            got.total_dx    = m_tdata[71:40];
            got.total_dy    = m_tdata[103:72];
            got.had_data    = m_tdata[104];
            if (reports_due.size() == 0)
            begin
                $error("result with no request outstanding: kind %0d", got.result_kind);
                mismatches++;
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("result_kind", want.result_kind, got.result_kind);
                check_field("move_dx", want.move_dx, got.move_dx);
                check_field("move_dy", want.move_dy, got.move_dy);
                check_field("wheel_delta", want.wheel_delta, got.wheel_delta);
                check_field("scroll_rows", want.scroll_rows, got.scroll_rows);
                check_field("buttons", want.buttons, got.buttons);
                check_field("total_dx", want.total_dx, got.total_dx);
                check_field("total_dy", want.total_dy, got.total_dy);
                check_field("had_data", want.had_data, got.had_data);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // 3-byte mode: empty poll, dropped bytes, extremes, overflow drops
        write_wheel_mode(1'b0);
        add_req(ACTION_POLL, 8'h00, 8'h00);
        add_req(ACTION_BYTE, 8'h20, 8'h08);
        add_req(ACTION_BYTE, 8'h01, 8'h08);
        add_req(ACTION_BYTE, 8'h00, 8'hFF);
        add_req(ACTION_BYTE, 8'h21, 8'hF7);
        add_req(ACTION_BYTE, 8'hFF, 8'h0F);
        add_req(ACTION_BYTE, 8'hFF, 8'hFF);
        add_req(ACTION_BYTE, 8'hFF, 8'h00);
        add_req(ACTION_BYTE, 8'h21, 8'h38);
        add_req(ACTION_BYTE, 8'h21, 8'h00);
        add_req(ACTION_BYTE, 8'h21, 8'h00);
        add_req(ACTION_BYTE, 8'h21, 8'h8F);
        add_req(ACTION_BYTE, 8'h21, 8'h12);
        add_req(ACTION_BYTE, 8'h21, 8'h34);
        add_req(ACTION_BYTE, 8'h21, 8'h48);
        add_req(ACTION_BYTE, 8'h21, 8'h56);
        add_req(ACTION_BYTE, 8'h21, 8'h78);
        add_req(ACTION_POLL, 8'hFF, 8'hFF);
        // Leave a packet two bytes in, then grow the packet size
        add_req(ACTION_BYTE, 8'h21, 8'h09);
        add_req(ACTION_BYTE, 8'h21, 8'h01);
        wait_idle();

        write_wheel_mode(1'b1);
        add_req(ACTION_BYTE, 8'h21, 8'h02);
        add_req(ACTION_BYTE, 8'h21, 8'h80);
        add_req(ACTION_BYTE, 8'h21, 8'h2C);
        add_req(ACTION_BYTE, 8'h21, 8'h7F);
        add_req(ACTION_BYTE, 8'h21, 8'h80);
        add_req(ACTION_BYTE, 8'h21, 8'h7F);
        // Leave a packet three bytes in, then shrink the packet size
        add_req(ACTION_BYTE, 8'h21, 8'h08);
        add_req(ACTION_BYTE, 8'h21, 8'h10);
        add_req(ACTION_BYTE, 8'h21, 8'h20);
        wait_idle();

        write_wheel_mode(1'b0);
        add_req(ACTION_BYTE, 8'h21, 8'h55);
        add_req(ACTION_POLL, 8'h00, 8'h00);
        wait_idle();

        // Random phases, alternating packet size; hold the result side once
        for (int ph = 0; ph < 4; ph++)
        begin
            write_wheel_mode((ph % 2) == 0);
            queue_random(215);
            if (ph == 0)
                hold_requests <= hold_requests + 1;
            add_req(ACTION_POLL, 8'($urandom), 8'($urandom), 1'b1);
            queue_random(210);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
